[design/oag_pkg.sv]
package oag_pkg;

	localparam logic [3:0] MODE_IMP = 4'd0;
	localparam logic [3:0] MODE_IMM = 4'd1;
	localparam logic [3:0] MODE_REL = 4'd2;
	localparam logic [3:0] MODE_ABS = 4'd3;
	localparam logic [3:0] MODE_ABX = 4'd4;
	localparam logic [3:0] MODE_ABY = 4'd5;
	localparam logic [3:0] MODE_IND = 4'd6;
	localparam logic [3:0] MODE_INX = 4'd7;
	localparam logic [3:0] MODE_INY = 4'd8;
	localparam logic [3:0] MODE_ZPG = 4'd9;
	localparam logic [3:0] MODE_ZPX = 4'd10;
	localparam logic [3:0] MODE_ZPY = 4'd11;
	localparam logic [3:0] OPC_READ = 4'd12;

	localparam logic [1:0] STEP_FIRST  = 2'd0;
	localparam logic [1:0] STEP_SECOND = 2'd1;
	localparam logic [1:0] STEP_THIRD  = 2'd2;

	localparam logic RES_READ = 1'b0;
	localparam logic RES_DONE = 1'b1;

	localparam logic [7:0] ZPH_RESET = 8'h20;

	typedef struct packed {
		logic [3:0]  opcode;
		logic [15:0] pc_value;
		logic [7:0]  x_value;
		logic [7:0]  y_value;
		logic [7:0]  read_data;
	} item_t;

	typedef struct packed {
		logic        result_kind;
		logic [15:0] address;
		logic [15:0] next_pc;
	} result_t;

	typedef struct packed {
		logic        busy;
		logic [3:0]  mode_held;
		logic [1:0]  step_count;
		logic [15:0] pc_held;
		logic [7:0]  x_held;
		logic [7:0]  y_held;
		logic [7:0]  pointer_byte;
		logic [7:0]  address_low;
	} state_t;

endpackage

[design/oag_in_if.sv]
interface oag_in_if;
	logic        valid;
	logic        ready;
	logic [3:0]  opcode;
	logic [15:0] pc_value;
	logic [7:0]  x_value;
	logic [7:0]  y_value;
	logic [7:0]  read_data;

	modport source (output valid, opcode, pc_value, x_value, y_value, read_data, input ready);
	modport sink   (input valid, opcode, pc_value, x_value, y_value, read_data, output ready);
endinterface

[design/oag_out_if.sv]
interface oag_out_if;
	logic        valid;
	logic        ready;
	logic        result_kind;
	logic [15:0] address;
	logic [15:0] next_pc;

	modport source (output valid, result_kind, address, next_pc, input ready);
	modport sink   (input valid, result_kind, address, next_pc, output ready);
endinterface

[design/oag_cfg_if.sv]
interface oag_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] zero_page_high;

	modport source (output valid, zero_page_high, input ready);
	modport sink   (input valid, zero_page_high, output ready);
endinterface

[design/oag_step.sv]
module oag_step (
	input  oag_pkg::item_t   item,
	input  oag_pkg::state_t  state,
	input  logic [7:0]       zph,
	output oag_pkg::state_t  state_nxt,
	output oag_pkg::result_t res
);

	logic [3:0]  op;
	logic [7:0]  d;
	logic [15:0] p;
	logic [7:0]  idx;
	logic [7:0]  ptr;
	logic [15:0] merged;

	assign op     = item.opcode;
	assign d      = item.read_data;
	assign p      = state.pc_held;
	assign merged = {d, state.address_low};
	assign ptr    = (state.mode_held == oag_pkg::MODE_INX) ? d + state.x_held : d;

	always_comb begin
		idx = 8'd0;
		if (state.mode_held inside {oag_pkg::MODE_ABX, oag_pkg::MODE_ZPX})
			idx = state.x_held;
		else if (state.mode_held inside {oag_pkg::MODE_ABY, oag_pkg::MODE_ZPY,
			oag_pkg::MODE_INY})
			idx = state.y_held;
	end

	always_comb begin
		state_nxt = state;
		res = '{result_kind: oag_pkg::RES_DONE, address: p, next_pc: p};
		if (op <= oag_pkg::MODE_ZPY) begin
			state_nxt.busy       = 1'b0;
			state_nxt.mode_held  = op;
			state_nxt.step_count = oag_pkg::STEP_FIRST;
			state_nxt.pc_held    = item.pc_value;
			state_nxt.x_held     = item.x_value;
			state_nxt.y_held     = item.y_value;
			res.address          = item.pc_value;
			case (op)
				oag_pkg::MODE_IMP: begin
					res.next_pc = item.pc_value;
				end
				oag_pkg::MODE_IMM, oag_pkg::MODE_REL: begin
					res.next_pc = item.pc_value + 16'd1;
				end
				default: begin
					state_nxt.busy  = 1'b1;
					res.result_kind = oag_pkg::RES_READ;
					res.next_pc     = 16'd0;
				end
			endcase
		end else if (state.busy) begin
			case (state.mode_held)
				oag_pkg::MODE_ABS, oag_pkg::MODE_ABX, oag_pkg::MODE_ABY: begin
					if (state.step_count == oag_pkg::STEP_FIRST) begin
						state_nxt.address_low = d;
						state_nxt.step_count  = oag_pkg::STEP_SECOND;
						res = '{result_kind: oag_pkg::RES_READ, address: p + 16'd1,
							next_pc: 16'd0};
					end else begin
						state_nxt.busy       = 1'b0;
						state_nxt.step_count = oag_pkg::STEP_FIRST;
						res = '{result_kind: oag_pkg::RES_DONE,
							address: merged + {8'd0, idx}, next_pc: p + 16'd2};
					end
				end
				oag_pkg::MODE_IND, oag_pkg::MODE_INX, oag_pkg::MODE_INY: begin
					if (state.step_count == oag_pkg::STEP_FIRST) begin
						state_nxt.pointer_byte = ptr;
						state_nxt.step_count   = oag_pkg::STEP_SECOND;
						res = '{result_kind: oag_pkg::RES_READ, address: {zph, ptr},
							next_pc: 16'd0};
					end else if (state.step_count == oag_pkg::STEP_SECOND) begin
						state_nxt.address_low = d;
						state_nxt.step_count  = oag_pkg::STEP_THIRD;
						res = '{result_kind: oag_pkg::RES_READ,
							address: {zph, state.pointer_byte + 8'd1}, next_pc: 16'd0};
					end else begin
						state_nxt.busy       = 1'b0;
						state_nxt.step_count = oag_pkg::STEP_FIRST;
						res = '{result_kind: oag_pkg::RES_DONE,
							address: merged + {8'd0, idx}, next_pc: p + 16'd1};
					end
				end
				default: begin
					state_nxt.busy       = 1'b0;
					state_nxt.step_count = oag_pkg::STEP_FIRST;
					res = '{result_kind: oag_pkg::RES_DONE, address: {zph, d + idx},
						next_pc: p + 16'd1};
				end
			endcase
		end
	end

endmodule

[design/cpu_operand_address_generator_unit.sv]
// An accepted operand is registered at the input, then its result at the output.
// Throughput: one transaction per cycle when results do not stall; the sequencer
// state register closes its loop through one short add/merge stage between input
// and result registers. Reset (arst_n low, asynchronous): sequencer idle, all
// held values zero, zero page high byte 0x20, both pipeline registers empty.
module cpu_operand_address_generator_unit (
	input logic      clk,
	input logic      arst_n,
	oag_in_if.sink   operand,
	oag_out_if.source result,
	oag_cfg_if.sink  cfg
);

	logic              valid_s1;
	oag_pkg::item_t    item_s1;
	logic              valid_s2;
	oag_pkg::result_t  res_s2;
	oag_pkg::state_t   state_q;
	oag_pkg::state_t   state_nxt;
	oag_pkg::result_t  res_nxt;
	logic [7:0]        zph_q;
	logic              advance;

	assign advance       = valid_s1 && (!valid_s2 || result.ready);
	assign operand.ready = !valid_s1 || advance;
	assign cfg.ready     = 1'b1;

	assign result.valid       = valid_s2;
	assign result.result_kind = res_s2.result_kind;
	assign result.address     = res_s2.address;
	assign result.next_pc     = res_s2.next_pc;

	oag_step u_step (
		.item      (item_s1),
		.state     (state_q),
		.zph       (zph_q),
		.state_nxt (state_nxt),
		.res       (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= '0;
			zph_q    <= oag_pkg::ZPH_RESET;
		end else begin
			if (cfg.valid && cfg.ready)
				zph_q <= cfg.zero_page_high;
			if (operand.valid && operand.ready)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
			if (advance) begin
				state_q  <= state_nxt;
				valid_s2 <= 1'b1;
			end else if (result.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (operand.valid && operand.ready)
			item_s1 <= '{opcode: operand.opcode, pc_value: operand.pc_value,
				x_value: operand.x_value, y_value: operand.y_value,
				read_data: operand.read_data};
		if (advance)
			res_s2 <= res_nxt;
	end

	a_step_needs_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.step_count != oag_pkg::STEP_FIRST |-> state_q.busy)
		else $error("step count set while sequencer idle");

	a_third_step_indirect: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.step_count == oag_pkg::STEP_THIRD |->
		(state_q.mode_held == oag_pkg::MODE_IND || state_q.mode_held == oag_pkg::MODE_INX ||
		state_q.mode_held == oag_pkg::MODE_INY))
		else $error("third step outside indirect modes");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.step_count != 2'd3)
		else $error("step count out of range");

	a_read_no_pc: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.result_kind == oag_pkg::RES_READ |-> res_s2.next_pc == 16'd0)
		else $error("read request carries a program counter");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> operand.ready)
		else $error("input stalled with empty result register");

endmodule
